FILE: src/lif_pkg.sv
// ============================================================================
// lif_pkg
// Shared types and constants for the leaky integrate-and-fire neuron.
// ============================================================================
package lif_pkg;

    // Spike history window. The slot arithmetic takes the low index bits of
    // the timestep, so the depth is kept to a power of two.
    localparam int HISTORY_DEPTH = 32;
    localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
    localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);

    // Field widths.
    localparam int Q_W        = 24;  // signed Q7.16 potential
    localparam int LEAK_W     = 16;  // unsigned Q0.16 leak factor
    localparam int STEP_W     = 32;  // timestep
    localparam int GAP_W      = 16;  // saturated elapsed step count
    localparam int COUNT_W    = 6;   // spike count result
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier: Q7.16 magnitude, Q1.16 power or Q0.16 base by a Q1.16 power or Q0.16 base.
    localparam int POW_W     = LEAK_W + 1;           // can hold exactly 1.0
    localparam int MUL_A_W   = Q_W;
    localparam int MUL_B_W   = POW_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int FRAC_W    = 16;
    localparam int RND_W     = MUL_P_W - FRAC_W;

    localparam logic [POW_W-1:0]   POW_ONE  = POW_W'(1) << FRAC_W;
    localparam logic [GAP_W-1:0]   GAP_MAX  = '1;
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_STEPS = 3'd4;

    // Register reset values.
    localparam logic signed [Q_W-1:0] FIRE_THRESHOLD_RST   = 24'sd65536;
    localparam logic [LEAK_W-1:0]     LEAK_FACTOR_RST      = 16'd58982;
    localparam logic signed [Q_W-1:0] REST_LEVEL_RST       = 24'sd0;
    localparam logic signed [Q_W-1:0] RESET_LEVEL_RST      = 24'sd0;
    localparam logic [GAP_W-1:0]      REFRACTORY_STEPS_RST = 16'd2;

    typedef enum logic {
        CMD_SYNAPSE = 1'b0,
        CMD_SPIKE   = 1'b1
    } t_command;

    typedef struct packed {
        t_command                command;
        logic [STEP_W-1:0]       step_time;
        logic signed [Q_W-1:0]   input_charge;
    } t_in_word;

    typedef struct packed {
        logic                    fired;
        logic signed [Q_W-1:0]   membrane_level;
        logic [COUNT_W-1:0]      spike_count;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ELAPSE,
        S_MULP,
        S_SQR,
        S_SCALE,
        S_ADD,
        S_OUT
    } t_state;

endpackage

FILE: src/lif_mul_unit.sv
// ============================================================================
// lif_mul_unit
// Shared unsigned multiplier with round-to-nearest removal of 16 fraction bits.
// ============================================================================
module lif_mul_unit (
    input  logic [lif_pkg::MUL_A_W-1:0] i_a,
    input  logic [lif_pkg::MUL_B_W-1:0] i_b,
    output logic [lif_pkg::RND_W-1:0]   o_round
);

    logic [lif_pkg::MUL_P_W-1:0] prod;
    logic [lif_pkg::MUL_P_W-1:0] prod_rnd;

    assign prod     = lif_pkg::MUL_P_W'(i_a) * lif_pkg::MUL_P_W'(i_b);
    // Half an LSB of the result is added before truncation: ties round up.
    assign prod_rnd = prod + (lif_pkg::MUL_P_W'(1) << (lif_pkg::FRAC_W - 1));
    assign o_round  = prod_rnd[lif_pkg::MUL_P_W-1:lif_pkg::FRAC_W];

endmodule

FILE: src/leaky_integrate_fire_neuron_top.sv
// ============================================================================
// leaky_integrate_fire_neuron_top
// Leaky integrate-and-fire neuron with Q7.16 potential and a spike history.
// ============================================================================
//
//   Channel   Direction  Handshake            Word
//   input     in         i_valid / o_ready    i_data  (command, step, charge)
//   result    out        o_valid / i_ready    o_data  (fired, level, count)
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Spike records and refractory synaptic words go from check to result. A
// decaying word runs check, elapse, a multiply and a square step per bit of
// gap (the elapsed step count saturated at 65535), scale, add and result:
// the leak power is built by square-and-multiply on one shared multiplier,
// one product per cycle. A word below rest or with no elapsed steps skips
// the power and scale steps. Reset is synchronous and active low; it restores
// the register defaults and clears the neuron state. A stalled result holds
// the sequencer in its final step, and o_ready is low until it is idle.
//
module leaky_integrate_fire_neuron_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  lif_pkg::t_in_word               i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output lif_pkg::t_out_word              o_data,
    input  logic                            i_cfg_we,
    input  logic [lif_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lif_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [lif_pkg::Q_W-1:0]  r_fire_threshold;
    logic [lif_pkg::LEAK_W-1:0]      r_leak_factor;
    logic signed [lif_pkg::Q_W-1:0]  r_rest_level;
    logic signed [lif_pkg::Q_W-1:0]  r_reset_level;
    logic [lif_pkg::GAP_W-1:0]       r_refractory_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire_threshold   <= lif_pkg::FIRE_THRESHOLD_RST;
            r_leak_factor      <= lif_pkg::LEAK_FACTOR_RST;
            r_rest_level       <= lif_pkg::REST_LEVEL_RST;
            r_reset_level      <= lif_pkg::RESET_LEVEL_RST;
            r_refractory_steps <= lif_pkg::REFRACTORY_STEPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lif_pkg::CFG_FIRE_THRESHOLD:   r_fire_threshold   <= i_cfg_data;
                lif_pkg::CFG_LEAK_FACTOR:      r_leak_factor      <= i_cfg_data[lif_pkg::LEAK_W-1:0];
                lif_pkg::CFG_REST_LEVEL:       r_rest_level       <= i_cfg_data;
                lif_pkg::CFG_RESET_LEVEL:      r_reset_level      <= i_cfg_data;
                lif_pkg::CFG_REFRACTORY_STEPS: r_refractory_steps <= i_cfg_data[lif_pkg::GAP_W-1:0];
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State and working registers.
    // ------------------------------------------------------------------
    lif_pkg::t_state r_state, n_state;

    // Captured input word.
    lif_pkg::t_command                r_cmd;
    logic [lif_pkg::STEP_W-1:0]       r_step;
    logic signed [lif_pkg::Q_W-1:0]   r_charge;

    // Neuron state.
    logic signed [lif_pkg::Q_W-1:0]     r_membrane,   n_membrane;
    logic [lif_pkg::STEP_W-1:0]         r_last_step,  n_last_step;
    logic [lif_pkg::STEP_W-1:0]         r_ref_start,  n_ref_start;
    logic                               r_ref_valid,  n_ref_valid;
    logic [lif_pkg::HISTORY_DEPTH-1:0]  r_hist,       n_hist;

    // Leak power loop.
    logic [lif_pkg::GAP_W-1:0]   r_gap,  n_gap;
    logic [lif_pkg::POW_W-1:0]   r_pow,  n_pow;
    logic [lif_pkg::LEAK_W-1:0]  r_base, n_base;
    logic [lif_pkg::Q_W-1:0]     r_mag,  n_mag;
    logic                        r_neg,  n_neg;
    logic                        r_fired, n_fired;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    lif_pkg::t_out_word   r_out,       n_out;

    // Shared multiplier operands.
    logic [lif_pkg::MUL_A_W-1:0] mul_a;
    logic [lif_pkg::MUL_B_W-1:0] mul_b;
    logic [lif_pkg::RND_W-1:0]   mul_rnd;

    lif_mul_unit u_mul (
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_round (mul_rnd)
    );

    // ------------------------------------------------------------------
    // Combinational helpers.
    // ------------------------------------------------------------------
    logic                              accept;
    logic                              out_free;
    logic [lif_pkg::STEP_W-1:0]        ref_age;
    logic                              refractory;
    logic [lif_pkg::STEP_W-1:0]        elapsed;
    logic                              elapsed_pos;
    logic [lif_pkg::GAP_W-1:0]         gap_sat;
    logic [lif_pkg::HISTORY_DEPTH-1:0] clear_mask;
    logic [lif_pkg::HISTORY_DEPTH-1:0] spike_bit;
    logic signed [lif_pkg::Q_W:0]      sum_wide;
    logic signed [lif_pkg::Q_W-1:0]    sum_sat;
    logic [lif_pkg::HIST_CNT_W-1:0]    pop_count;
    logic [lif_pkg::COUNT_W-1:0]       count_sat;
    logic [lif_pkg::Q_W-1:0]           scaled_mag;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // The neuron is refractory while fewer than refractory_steps steps have
    // passed since it last fired; the age wraps like the timestep does.
    assign ref_age    = r_step - r_ref_start;
    assign refractory = r_ref_valid &&
                        (ref_age < lif_pkg::STEP_W'(r_refractory_steps));

    // Elapsed steps count only when the difference is positive read as a
    // signed value; same-step or backwards time applies no decay or history clearing.
    assign elapsed     = r_step - r_last_step;
    assign elapsed_pos = (elapsed != '0) && !elapsed[lif_pkg::STEP_W-1];
    assign gap_sat     = (elapsed[lif_pkg::STEP_W-1:lif_pkg::GAP_W] != '0) ?
                         lif_pkg::GAP_MAX : elapsed[lif_pkg::GAP_W-1:0];

    // Skipped-over history slots are stale: slot j is cleared when its distance
    // ahead of the current slot is 1 to gap - 1, or always once gap reaches 32.
    always_comb begin
        logic [lif_pkg::HIST_IDX_W-1:0] slot_ahead;
        for (int j = 0; j < lif_pkg::HISTORY_DEPTH; j++) begin
            slot_ahead = lif_pkg::HIST_IDX_W'(j) - r_step[lif_pkg::HIST_IDX_W-1:0];
            if (gap_sat >= lif_pkg::GAP_W'(lif_pkg::HISTORY_DEPTH)) begin
                clear_mask[j] = 1'b1;
            end else begin
                clear_mask[j] = (slot_ahead != '0) &&
                                (lif_pkg::GAP_W'(slot_ahead) < gap_sat);
            end
        end
    end

    assign spike_bit = lif_pkg::HISTORY_DEPTH'(1) << r_step[lif_pkg::HIST_IDX_W-1:0];

    // Charge is added with saturation to the Q7.16 range.
    assign sum_wide = {r_membrane[lif_pkg::Q_W-1], r_membrane} +
                      {r_charge[lif_pkg::Q_W-1], r_charge};
    always_comb begin
        if (sum_wide[lif_pkg::Q_W] != sum_wide[lif_pkg::Q_W-1]) begin
            sum_sat = sum_wide[lif_pkg::Q_W] ? lif_pkg::Q_MIN : lif_pkg::Q_MAX;
        end else begin
            sum_sat = sum_wide[lif_pkg::Q_W-1:0];
        end
    end

    // Spike count over the history window.
    always_comb begin
        pop_count = '0;
        for (int j = 0; j < lif_pkg::HISTORY_DEPTH; j++) begin
            pop_count = pop_count + lif_pkg::HIST_CNT_W'(r_hist[j]);
        end
    end
    assign count_sat = (lif_pkg::HIST_CNT_W > lif_pkg::COUNT_W &&
                        pop_count > lif_pkg::HIST_CNT_W'(lif_pkg::COUNT_MAX)) ?
                       lif_pkg::COUNT_MAX : lif_pkg::COUNT_W'(pop_count);

    assign scaled_mag = mul_rnd[lif_pkg::Q_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lif_pkg::S_IDLE: begin
                if (accept) n_state = lif_pkg::S_CHECK;
            end
            lif_pkg::S_CHECK: begin
                if (r_cmd == lif_pkg::CMD_SPIKE || refractory) begin
                    n_state = lif_pkg::S_OUT;
                end else begin
                    n_state = lif_pkg::S_ELAPSE;
                end
            end
            lif_pkg::S_ELAPSE: begin
                if (r_membrane < r_rest_level || !elapsed_pos) begin
                    n_state = lif_pkg::S_ADD;
                end else begin
                    n_state = lif_pkg::S_MULP;
                end
            end
            lif_pkg::S_MULP: begin
                n_state = lif_pkg::S_SQR;
            end
            lif_pkg::S_SQR: begin
                // No higher gap bits left: the power is complete.
                if (r_gap[lif_pkg::GAP_W-1:1] == '0) begin
                    n_state = lif_pkg::S_SCALE;
                end else begin
                    n_state = lif_pkg::S_MULP;
                end
            end
            lif_pkg::S_SCALE: begin
                n_state = lif_pkg::S_ADD;
            end
            lif_pkg::S_ADD: begin
                n_state = lif_pkg::S_OUT;
            end
            lif_pkg::S_OUT: begin
                if (out_free) n_state = lif_pkg::S_IDLE;
            end
            default: n_state = lif_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and datapath updates.
    // ------------------------------------------------------------------
    always_comb begin
        o_ready     = (r_state == lif_pkg::S_IDLE);
        mul_a       = '0;
        mul_b       = '0;
        n_membrane  = r_membrane;
        n_last_step = r_last_step;
        n_ref_start = r_ref_start;
        n_ref_valid = r_ref_valid;
        n_hist      = r_hist;
        n_gap       = r_gap;
        n_pow       = r_pow;
        n_base      = r_base;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_fired     = r_fired;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        unique case (r_state)
            lif_pkg::S_IDLE: begin
                n_fired = 1'b0;
            end
            lif_pkg::S_CHECK: begin
                if (r_cmd == lif_pkg::CMD_SPIKE) begin
                    n_hist = r_hist | spike_bit;
                end
            end
            lif_pkg::S_ELAPSE: begin
                if (r_membrane < r_rest_level) begin
                    n_membrane = r_rest_level;
                end else if (elapsed_pos) begin
                    n_gap  = gap_sat;
                    n_pow  = lif_pkg::POW_ONE;
                    n_base = r_leak_factor;
                    n_hist = r_hist & ~clear_mask;
                    n_neg  = r_membrane[lif_pkg::Q_W-1];
                    n_mag  = r_membrane[lif_pkg::Q_W-1] ?
                             (~r_membrane + lif_pkg::Q_W'(1)) : r_membrane;
                end
            end
            lif_pkg::S_MULP: begin
                mul_a = lif_pkg::MUL_A_W'(r_pow);
                mul_b = lif_pkg::MUL_B_W'(r_base);
                if (r_gap[0]) n_pow = mul_rnd[lif_pkg::POW_W-1:0];
            end
            lif_pkg::S_SQR: begin
                mul_a  = lif_pkg::MUL_A_W'(r_base);
                mul_b  = lif_pkg::MUL_B_W'(r_base);
                n_base = mul_rnd[lif_pkg::LEAK_W-1:0];
                n_gap  = r_gap >> 1;
            end
            lif_pkg::S_SCALE: begin
                // Magnitude is scaled so the rounding goes away from zero.
                mul_a      = r_mag;
                mul_b      = r_pow;
                n_membrane = r_neg ? (~scaled_mag + lif_pkg::Q_W'(1)) : scaled_mag;
            end
            lif_pkg::S_ADD: begin
                n_last_step = r_step;
                if (sum_sat >= r_fire_threshold) begin
                    n_ref_start = r_step;
                    n_ref_valid = 1'b1;
                    n_membrane  = r_reset_level;
                    n_fired     = 1'b1;
                end else begin
                    n_membrane  = sum_sat;
                end
            end
            lif_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.fired          = r_fired;
                    n_out.membrane_level = r_membrane;
                    n_out.spike_count    = count_sat;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lif_pkg::S_IDLE;
            r_membrane  <= '0;
            r_last_step <= '0;
            r_ref_start <= '0;
            r_ref_valid <= 1'b0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
            r_fired     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_membrane  <= n_membrane;
            r_last_step <= n_last_step;
            r_ref_start <= n_ref_start;
            r_ref_valid <= n_ref_valid;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
            r_fired     <= n_fired;
        end
    end

    // Payload and loop registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_data.command;
            r_step   <= i_data.step_time;
            r_charge <= i_data.input_charge;
        end
        r_gap  <= n_gap;
        r_pow  <= n_pow;
        r_base <= n_base;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: src/lif_checker.sv
// ============================================================================
// lif_checker
// Port-level checks for the leaky integrate-and-fire neuron.
// ============================================================================
module lif_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  lif_pkg::t_out_word              o_data
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // One word at a time: the block is busy in the cycle after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an accept");

    // A new result only appears at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without work in progress");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    // The spike count never exceeds the history window.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.spike_count <= lif_pkg::COUNT_W'(lif_pkg::HISTORY_DEPTH)))
        else $error("spike count beyond history depth");

endmodule

bind leaky_integrate_fire_neuron_top lif_checker u_lif_checker (.*);

FILE: verif/tb_leaky_integrate_fire_neuron_top.sv
// ============================================================================
// tb_leaky_integrate_fire_neuron_top
// Self-checking bench for the leaky integrate-and-fire neuron. A bit-exact
// model of the neuron predicts every result word, and a scoreboard compares
// each returned word field by field. Traffic runs under several register
// settings and back-pressure mixes, and includes one long result stall.
// ============================================================================

class neuron_scoreboard;
    logic signed [lif_pkg::Q_W-1:0]     thresh;
    logic [lif_pkg::LEAK_W-1:0]         leak;
    logic signed [lif_pkg::Q_W-1:0]     rest_lvl;
    logic signed [lif_pkg::Q_W-1:0]     fire_lvl;
    logic [lif_pkg::GAP_W-1:0]          refr_len;

    logic signed [lif_pkg::Q_W-1:0]     membrane;
    logic [lif_pkg::STEP_W-1:0]         last_step;
    logic [lif_pkg::STEP_W-1:0]         refr_start;
    bit                                 refr_armed;
    logic [lif_pkg::HISTORY_DEPTH-1:0]  history;

    lif_pkg::t_out_word                 predicted_words[$];
    int                                 errors;

    function new();
        thresh     = lif_pkg::FIRE_THRESHOLD_RST;
        leak       = lif_pkg::LEAK_FACTOR_RST;
        rest_lvl   = lif_pkg::REST_LEVEL_RST;
        fire_lvl   = lif_pkg::RESET_LEVEL_RST;
        refr_len   = lif_pkg::REFRACTORY_STEPS_RST;
        membrane   = '0;
        last_step  = '0;
        refr_start = '0;
        refr_armed = 1'b0;
        history    = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [lif_pkg::CFG_IDX_W-1:0] idx,
                            logic [lif_pkg::CFG_DATA_W-1:0] data);
        unique case (idx)
            lif_pkg::CFG_FIRE_THRESHOLD:   thresh   = data;
            lif_pkg::CFG_LEAK_FACTOR:      leak     = data[lif_pkg::LEAK_W-1:0];
            lif_pkg::CFG_REST_LEVEL:       rest_lvl = data;
            lif_pkg::CFG_RESET_LEVEL:      fire_lvl = data;
            lif_pkg::CFG_REFRACTORY_STEPS: refr_len = data[lif_pkg::GAP_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return predicted_words.size();
    endfunction

    // Advance the neuron by one accepted word and queue the word it returns.
    function void note_input(lif_pkg::t_in_word w);
        lif_pkg::t_out_word         o;
        longint                     m;
        longint                     prod;
        longint unsigned            p;
        longint unsigned            b;
        logic [lif_pkg::STEP_W-1:0] t;
        logic [lif_pkg::STEP_W-1:0] d;
        int unsigned                n;
        int unsigned                steps;
        int                         c;

        t       = w.step_time;
        o.fired = 1'b0;
        if (w.command == lif_pkg::CMD_SPIKE) begin
            history[t[lif_pkg::HIST_IDX_W-1:0]] = 1'b1;
        end else if (!(refr_armed && ((t - refr_start) < {16'b0, refr_len}))) begin
            m = membrane;
            if (m < rest_lvl) begin
                m = rest_lvl;
            end else begin
                d = t - last_step;
                if (d != 0 && !d[lif_pkg::STEP_W-1]) begin
                    steps = (d > 65535) ? 65535 : d;
                    // Leak power by square-and-multiply, each product rounded
                    // to nearest with ties up.
                    p = 65536;
                    b = leak;
                    n = steps;
                    while (n != 0) begin
                        if (n & 1)
                            p = (p * b + 32768) >> 16;
                        b = (b * b + 32768) >> 16;
                        n = n >> 1;
                    end
                    // Final scaling rounds ties away from zero.
                    prod = m * longint'(p);
                    if (prod >= 0)
                        m = (prod + 32768) >>> 16;
                    else
                        m = -((-prod + 32768) >>> 16);
                    if (steps >= lif_pkg::HISTORY_DEPTH) begin
                        history = '0;
                    end else begin
                        for (int i = 1; i < steps; i++)
                            history[lif_pkg::HIST_IDX_W'(t + i)] = 1'b0;
                    end
                end
            end
            m = m + longint'(w.input_charge);
            if (m > longint'(lif_pkg::Q_MAX))
                m = lif_pkg::Q_MAX;
            if (m < longint'(lif_pkg::Q_MIN))
                m = lif_pkg::Q_MIN;
            last_step = t;
            if (m >= longint'(thresh)) begin
                refr_start = t;
                refr_armed = 1'b1;
                m          = fire_lvl;
                o.fired    = 1'b1;
            end
            membrane = m[lif_pkg::Q_W-1:0];
        end
        o.membrane_level = membrane;
        c = $countones(history);
        o.spike_count = (c > lif_pkg::COUNT_MAX) ? lif_pkg::COUNT_MAX :
                        c[lif_pkg::COUNT_W-1:0];
        predicted_words = {predicted_words, o};
    endfunction

    function void check_result(lif_pkg::t_out_word r);
        lif_pkg::t_out_word e;

        if (predicted_words.size() == 0) begin
            $error("result word arrived with no prediction pending");
            errors++;
            return;
        end
        e = predicted_words.pop_front();
        if (r.fired !== e.fired) begin
            $error("fired: expected %0d, actual %0d", e.fired, r.fired);
            errors++;
        end
        if (r.membrane_level !== e.membrane_level) begin
            $error("membrane_level: expected %0d, actual %0d",
                   e.membrane_level, r.membrane_level);
            errors++;
        end
        if (r.spike_count !== e.spike_count) begin
            $error("spike_count: expected %0d, actual %0d", e.spike_count, r.spike_count);
            errors++;
        end
    endfunction
endclass

module tb_leaky_integrate_fire_neuron_top;

    localparam int WORDS_PER_PHASE = 142;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 300;  // long result stall for the pressure test
    localparam int TAIL_CYCLES     = 40;   // idle tail beyond the worst-case latency
    localparam int Q_HI            = lif_pkg::Q_MAX;
    localparam int Q_LO            = lif_pkg::Q_MIN;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    lif_pkg::t_in_word              i_data      = '0;
    logic                           i_ready     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [lif_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lif_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           o_ready;
    logic                           o_valid;
    lif_pkg::t_out_word             o_data;

    neuron_scoreboard               sb;

    // Back-pressure knobs. The sender's idle rate belongs to the stimulus
    // process; the receiver's stall rate is handed over with a nonblocking
    // write so the receiver always sees a settled value.
    int                             send_idle     = 0;
    int                             recv_stall    = 0;
    bit                             pressure_tgl  = 1'b0;
    bit                             pressure_seen = 1'b0;
    int                             hold_left     = 0;

    logic [lif_pkg::STEP_W-1:0]     cur_t;
    int                             words_sent    = 0;

    leaky_integrate_fire_neuron_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Every input and result word is observed at the edge where its handshake
    // completes. All signals involved change only through nonblocking writes,
    // so the values seen here are the ones the block sampled at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_input(i_data);
            if (o_valid && i_ready)
                sb.check_result(o_data);
        end
    end

    // Result receiver. It stalls at random at the current rate, and when the
    // stimulus flips the pressure toggle it holds ready low for a long stretch
    // so that a result sits in the block and the input side backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                i_ready   <= 1'b0;
                hold_left  = hold_left - 1;
            end else if (pressure_tgl != pressure_seen) begin
                pressure_seen = pressure_tgl;
                hold_left     = HOLD_CYCLES;
                i_ready      <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Charges cluster around typical threshold levels, with full-range and
    // tiny values mixed in so that every bit toggles and saturation occurs.
    function automatic int random_charge();
        int r;

        r = $urandom_range(99);
        if (r < 50)
            return rand_between(-(2 << 16), 3 << 16);
        else if (r < 75)
            return rand_between(Q_LO, Q_HI);
        else if (r < 88)
            return rand_between(-256, 256);
        else
            return rand_between(-(16 << 16), 32 << 16);
    endfunction

    task automatic set_idling(t_idle_mode mode);
        unique case (mode)
            IDLE_NONE:     begin send_idle = 0;  recv_stall <= 0;  end
            IDLE_SENDER:   begin send_idle = 76; recv_stall <= 0;  end
            IDLE_RECEIVER: begin send_idle = 0;  recv_stall <= 76; end
            default:       begin send_idle = 12; recv_stall <= 12; end
        endcase
    endtask

    // Offer one word, possibly after a few idle cycles, and return at the
    // edge where it is accepted. Valid stays high with a stable word until
    // then.
    task automatic send_word(lif_pkg::t_command cmd, logic [lif_pkg::STEP_W-1:0] t,
                             int charge);
        lif_pkg::t_in_word w;

        w.command      = cmd;
        w.step_time    = t;
        w.input_charge = charge[lif_pkg::Q_W-1:0];
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [lif_pkg::CFG_IDX_W-1:0] idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= lif_pkg::CFG_DATA_W'(value);
        sb.write_reg(idx, lif_pkg::CFG_DATA_W'(value));
        @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic apply_settings(int thr, int lk, int rs, int rl, int rf);
        cfg_write(lif_pkg::CFG_FIRE_THRESHOLD, thr);
        cfg_write(lif_pkg::CFG_LEAK_FACTOR, lk);
        cfg_write(lif_pkg::CFG_REST_LEVEL, rs);
        cfg_write(lif_pkg::CFG_RESET_LEVEL, rl);
        cfg_write(lif_pkg::CFG_REFRACTORY_STEPS, rf);
        i_cfg_we <= 1'b0;
    endtask

    // Once the neuron is quiet, send a charge at the last update step that
    // lands the potential exactly on the threshold, or offset below it. With
    // no elapsed steps there is no decay, so the landing point is exact.
    task automatic near_threshold(int offset);
        longint base;
        longint c;

        settle_outputs();
        base = (sb.membrane < sb.rest_lvl) ? sb.rest_lvl : sb.membrane;
        c    = longint'(sb.thresh) - base - offset;
        if (c > Q_HI)
            c = Q_HI;
        if (c < Q_LO)
            c = Q_LO;
        cur_t = sb.last_step;
        send_word(lif_pkg::CMD_SYNAPSE, cur_t, int'(c));
    endtask

    // Short directed run under the reset settings: threshold 1.0, rest and
    // reset level 0, two refractory steps.
    task automatic directed_items();
        send_word(lif_pkg::CMD_SYNAPSE, 32'd0, 0);            // same step as reset, no decay
        send_word(lif_pkg::CMD_SPIKE,   32'd0, 0);
        send_word(lif_pkg::CMD_SPIKE,   32'd31, Q_LO);        // a spike record ignores its charge
        send_word(lif_pkg::CMD_SYNAPSE, 32'd1, Q_HI);         // reaches the top of the range and fires
        send_word(lif_pkg::CMD_SYNAPSE, 32'd2, 100);          // inside the refractory window
        send_word(lif_pkg::CMD_SYNAPSE, 32'd3, Q_LO);         // window over, reaches the bottom of the range
        send_word(lif_pkg::CMD_SYNAPSE, 32'd3, 1000);         // below rest, raised to rest
        send_word(lif_pkg::CMD_SPIKE,   32'd5, 0);
        send_word(lif_pkg::CMD_SPIKE,   32'd6, 0);
        send_word(lif_pkg::CMD_SPIKE,   32'd14, 0);
        send_word(lif_pkg::CMD_SPIKE,   32'd20, 0);
        send_word(lif_pkg::CMD_SYNAPSE, 32'd4, 50000);        // single-step decay
        send_word(lif_pkg::CMD_SYNAPSE, 32'd2, 10);           // time going backwards
        send_word(lif_pkg::CMD_SYNAPSE, 32'd10, 20000);       // clears the slots 11 to 15
        send_word(lif_pkg::CMD_SYNAPSE, 32'd50, 30000);       // gap clears the whole history
        send_word(lif_pkg::CMD_SYNAPSE, 32'd100050, 40000);   // gap saturates at 65535
        send_word(lif_pkg::CMD_SYNAPSE, 32'hFFFF_FFF0, -20000); // elapsed count reads negative
        near_threshold(1);                                    // one below threshold
        near_threshold(0);                                    // exactly at threshold
        send_word(lif_pkg::CMD_SYNAPSE, 32'hFFFF_FFFF, Q_HI); // fires at the top of the range
        send_word(lif_pkg::CMD_SYNAPSE, 32'd0, 500);          // refractory across the wrap
        send_word(lif_pkg::CMD_SYNAPSE, 32'd1, 500);          // window closed, decay across wrap
        cur_t = 32'd1;
    endtask

    // One random stimulus step. Most traffic is synaptic words on a mostly
    // advancing timeline, with spike records near the current step, bursts
    // that fill the whole history, and precise threshold hits.
    task automatic random_item();
        int r;
        int k;

        r = $urandom_range(99);
        if (r < 2) begin
            for (k = 0; k < lif_pkg::HISTORY_DEPTH; k++)
                send_word(lif_pkg::CMD_SPIKE, cur_t + k, random_charge());
        end else if (r < 20) begin
            send_word(lif_pkg::CMD_SPIKE, cur_t - $urandom_range(2), random_charge());
        end else if (r < 25) begin
            near_threshold($urandom_range(1));
        end else begin
            r = $urandom_range(99);
            if (r < 25)
                cur_t = cur_t;
            else if (r < 65)
                cur_t = cur_t + $urandom_range(3, 1);
            else if (r < 80)
                cur_t = cur_t + $urandom_range(40, 4);
            else if (r < 88)
                cur_t = cur_t + $urandom_range(100000, 41);
            else if (r < 93)
                cur_t = cur_t - $urandom_range(8, 1);
            else if (r < 97)
                cur_t = $urandom();
            else
                cur_t = cur_t + 32'h8000_0000 + $urandom_range(3);
            send_word(lif_pkg::CMD_SYNAPSE, cur_t, random_charge());
        end
    endtask

    initial begin
        int target;
        bit pressure_done;

        sb            = new();
        cur_t         = '0;
        pressure_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        directed_items();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_outputs();
            repeat (2) @(posedge i_clk);
            case (ph)
                // The first phase keeps the reset settings.
                1: apply_settings(196608, 60000, -65536, -32768, 3);
                // Upper and lower extremes of every register.
                2: apply_settings(Q_HI, 65535, Q_LO, Q_HI, 65535);
                3: apply_settings(Q_LO, 0, Q_HI, Q_LO, 0);
                4: apply_settings(rand_between(1 << 16, 8 << 16),
                                  rand_between(40000, 65535),
                                  rand_between(-(4 << 16), 0),
                                  rand_between(-(2 << 16), 1 << 16),
                                  rand_between(0, 6));
                5: apply_settings(rand_between(-(2 << 16), 2 << 16),
                                  rand_between(0, 65535),
                                  rand_between(-(8 << 16), 2 << 16),
                                  rand_between(Q_LO, Q_HI),
                                  rand_between(0, 40));
                default: ;
            endcase
            set_idling(t_idle_mode'(ph % 4));
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) begin
                // Early in the receiver-stall phase, start the long hold.
                if (ph == 2 && !pressure_done && words_sent > target - WORDS_PER_PHASE + 20) begin
                    pressure_tgl  <= ~pressure_tgl;
                    pressure_done  = 1'b1;
                end
                random_item();
            end
        end

        settle_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #2400000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
src/lif_pkg.sv
src/lif_mul_unit.sv
src/leaky_integrate_fire_neuron_top.sv
src/lif_checker.sv
verif/tb_leaky_integrate_fire_neuron_top.sv
